/* design/hsv2rgb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, hexcone constants, sector codes and pipeline control type.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HueW   = 13;
  localparam int SatW   = 9;
  localparam int ValW   = 9;
  localparam int ChanW  = 8;

  localparam int NumStages = 6;

  localparam logic [HueW-1:0] HUE_FULL   = 13'd5760;
  localparam logic [HueW-1:0] HUE_SECTOR = 13'd960;
  localparam logic [SatW-1:0] UNIT       = 9'd256;

  // floor(z / 15) = (z * RECIP_15) >> RECIP_SHIFT, exact for z below 2^16
  localparam logic [15:0] RECIP_15    = 16'd34953;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic [2:0] {
    SECT_RY,
    SECT_YG,
    SECT_GC,
    SECT_CB,
    SECT_BM,
    SECT_MR
  } sector_t;

  typedef struct packed {
    logic [NumStages-1:0] load;
  } pipe_ctrl_t;

endpackage

/* design/hsv2rgb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB channel interfaces
// Valid/ready channels for the HSV input word and the RGB result word.
// ----------------------------------------------------------------------------
interface hsv2rgb_in_if;
  logic                           valid;
  logic                           ready;
  logic [hsv2rgb_pkg::HueW-1:0]   hue;
  logic [hsv2rgb_pkg::SatW-1:0]   saturation;
  logic [hsv2rgb_pkg::ValW-1:0]   brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsv2rgb_out_if;
  logic                           valid;
  logic                           ready;
  logic [hsv2rgb_pkg::ChanW-1:0]  red;
  logic [hsv2rgb_pkg::ChanW-1:0]  green;
  logic [hsv2rgb_pkg::ChanW-1:0]  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* design/hsv2rgb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB datapath
// Six register stages: wrap/saturate, sector and chroma product, weighted
// product, numerator sum, scale by 255, divide by 15 and channel select.
// ----------------------------------------------------------------------------
module hsv2rgb_datapath (
  input  logic                            clk,
  input  hsv2rgb_pkg::pipe_ctrl_t         ctrl,
  input  logic [hsv2rgb_pkg::HueW-1:0]    hue,
  input  logic [hsv2rgb_pkg::SatW-1:0]    saturation,
  input  logic [hsv2rgb_pkg::ValW-1:0]    brightness,
  output logic [hsv2rgb_pkg::ChanW-1:0]   red,
  output logic [hsv2rgb_pkg::ChanW-1:0]   green,
  output logic [hsv2rgb_pkg::ChanW-1:0]   blue
);

  // stage 1: wrapped hue, saturated s and v
  logic [12:0] h1_r, h1_nxt;
  logic [8:0]  s1_r, s1_nxt;
  logic [8:0]  v1_r, v1_nxt;

  // stage 2
  hsv2rgb_pkg::sector_t sect2_r, sect2_nxt;
  logic [9:0]  w2_r, w2_nxt;
  logic [16:0] p2_r, p2_nxt;
  logic [8:0]  v2_r;
  logic [12:0] base2;
  logic        odd2;
  logic [12:0] rem2;
  logic [17:0] prod2;

  // stage 3
  hsv2rgb_pkg::sector_t sect3_r;
  logic [25:0] pw3_r, pw3_nxt;
  logic [16:0] d3_r, d3_nxt;
  logic [8:0]  v3_r;
  logic [26:0] prod3;

  // stage 4
  hsv2rgb_pkg::sector_t sect4_r;
  logic [25:0] n4_r, n4_nxt;
  logic [7:0]  cch4_r, cch4_nxt;
  logic [7:0]  zch4_r, zch4_nxt;
  logic [26:0] sum4;
  logic [16:0] cprod4;
  logic [24:0] zprod4;

  // stage 5
  hsv2rgb_pkg::sector_t sect5_r;
  logic [11:0] z5_r, z5_nxt;
  logic [7:0]  cch5_r;
  logic [7:0]  zch5_r;
  logic [33:0] prod5;

  // stage 6: output word
  logic [7:0]  red_r, red_nxt;
  logic [7:0]  green_r, green_nxt;
  logic [7:0]  blue_r, blue_nxt;
  logic [27:0] q6;
  logic [7:0]  xch6;

  always_comb begin
    h1_nxt = (hue >= hsv2rgb_pkg::HUE_FULL) ? hue - hsv2rgb_pkg::HUE_FULL : hue;
    s1_nxt = (saturation > hsv2rgb_pkg::UNIT) ? hsv2rgb_pkg::UNIT : saturation;
    v1_nxt = (brightness > hsv2rgb_pkg::UNIT) ? hsv2rgb_pkg::UNIT : brightness;
  end

  always_comb begin
    if (h1_r >= 13'(5 * hsv2rgb_pkg::HUE_SECTOR)) begin
      sect2_nxt = hsv2rgb_pkg::SECT_MR;
      base2     = 13'(5 * hsv2rgb_pkg::HUE_SECTOR);
      odd2      = 1'b1;
    end else if (h1_r >= 13'(4 * hsv2rgb_pkg::HUE_SECTOR)) begin
      sect2_nxt = hsv2rgb_pkg::SECT_BM;
      base2     = 13'(4 * hsv2rgb_pkg::HUE_SECTOR);
      odd2      = 1'b0;
    end else if (h1_r >= 13'(3 * hsv2rgb_pkg::HUE_SECTOR)) begin
      sect2_nxt = hsv2rgb_pkg::SECT_CB;
      base2     = 13'(3 * hsv2rgb_pkg::HUE_SECTOR);
      odd2      = 1'b1;
    end else if (h1_r >= 13'(2 * hsv2rgb_pkg::HUE_SECTOR)) begin
      sect2_nxt = hsv2rgb_pkg::SECT_GC;
      base2     = 13'(2 * hsv2rgb_pkg::HUE_SECTOR);
      odd2      = 1'b0;
    end else if (h1_r >= hsv2rgb_pkg::HUE_SECTOR) begin
      sect2_nxt = hsv2rgb_pkg::SECT_YG;
      base2     = hsv2rgb_pkg::HUE_SECTOR;
      odd2      = 1'b1;
    end else begin
      sect2_nxt = hsv2rgb_pkg::SECT_RY;
      base2     = 13'd0;
      odd2      = 1'b0;
    end
    rem2   = h1_r - base2;
    w2_nxt = odd2 ? hsv2rgb_pkg::HUE_SECTOR[9:0] - rem2[9:0] : rem2[9:0];
    prod2  = {9'd0, s1_r} * {9'd0, v1_r};
    p2_nxt = prod2[16:0];
  end

  always_comb begin
    prod3   = {10'd0, p2_r} * {17'd0, w2_r};
    pw3_nxt = prod3[25:0];
    d3_nxt  = {v2_r, 8'd0} - p2_r;
  end

  always_comb begin
    // numerator 960*d + p*w, with 960 = 1024 - 64
    sum4     = {d3_r, 10'd0} - {4'd0, d3_r, 6'd0} + {1'b0, pw3_r};
    n4_nxt   = sum4[25:0];
    cprod4   = {v3_r, 8'd0} - {8'd0, v3_r};
    cch4_nxt = cprod4[15:8];
    zprod4   = {d3_r, 8'd0} - {8'd0, d3_r};
    zch4_nxt = zprod4[23:16];
  end

  always_comb begin
    prod5  = {n4_r, 8'd0} - {8'd0, n4_r};
    z5_nxt = prod5[33:22];
  end

  always_comb begin
    q6   = {4'd0, z5_r} * {12'd0, hsv2rgb_pkg::RECIP_15};
    xch6 = q6[hsv2rgb_pkg::RECIP_SHIFT +: 8];
    case (sect5_r)
      hsv2rgb_pkg::SECT_RY: begin
        red_nxt = cch5_r; green_nxt = xch6;   blue_nxt = zch5_r;
      end
      hsv2rgb_pkg::SECT_YG: begin
        red_nxt = xch6;   green_nxt = cch5_r; blue_nxt = zch5_r;
      end
      hsv2rgb_pkg::SECT_GC: begin
        red_nxt = zch5_r; green_nxt = cch5_r; blue_nxt = xch6;
      end
      hsv2rgb_pkg::SECT_CB: begin
        red_nxt = zch5_r; green_nxt = xch6;   blue_nxt = cch5_r;
      end
      hsv2rgb_pkg::SECT_BM: begin
        red_nxt = xch6;   green_nxt = zch5_r; blue_nxt = cch5_r;
      end
      default: begin
        red_nxt = cch5_r; green_nxt = zch5_r; blue_nxt = xch6;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      h1_r <= h1_nxt;
      s1_r <= s1_nxt;
      v1_r <= v1_nxt;
    end
    if (ctrl.load[1]) begin
      sect2_r <= sect2_nxt;
      w2_r    <= w2_nxt;
      p2_r    <= p2_nxt;
      v2_r    <= v1_r;
    end
    if (ctrl.load[2]) begin
      sect3_r <= sect2_r;
      pw3_r   <= pw3_nxt;
      d3_r    <= d3_nxt;
      v3_r    <= v2_r;
    end
    if (ctrl.load[3]) begin
      sect4_r <= sect3_r;
      n4_r    <= n4_nxt;
      cch4_r  <= cch4_nxt;
      zch4_r  <= zch4_nxt;
    end
    if (ctrl.load[4]) begin
      sect5_r <= sect4_r;
      z5_r    <= z5_nxt;
      cch5_r  <= cch4_r;
      zch5_r  <= zch4_r;
    end
    if (ctrl.load[5]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

/* design/hsv_to_rgb_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Hexcone conversion, one HSV pixel per clock unless stalled, to 8-bit RGB.
// ----------------------------------------------------------------------------
// Usage:
//   in_pix carries hue (1/16 degree), saturation and brightness (256 = 1.0)
//   on a valid/ready handshake; out_pix returns red, green and blue words.
//   Each accepted word passes through one register stage per step:
//   wrap/saturate, sector and s*v product, weighted product, numerator sum,
//   scale by 255, divide by 15 and channel select.
//   Throughput is one word per cycle while out_pix.ready stays high;
//   each stage has its own valid bit.
//   A stalled receiver holds the output word; upstream stages keep advancing
//   into empty slots, and in_pix.ready drops only once every stage is full.
//   Reset clears all valid bits; in_pix.ready is high right after reset.
//   No configuration and no state is carried from one word to the next.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic                clk,
  input  logic                rst_n,
  hsv2rgb_in_if.sink          in_pix,
  hsv2rgb_out_if.source       out_pix
);

  localparam int LastStage = hsv2rgb_pkg::NumStages - 1;

  logic [hsv2rgb_pkg::NumStages-1:0] vld_r, vld_nxt;
  logic [hsv2rgb_pkg::NumStages-1:0] adv;
  hsv2rgb_pkg::pipe_ctrl_t           ctrl;
  logic                              in_acc;
  logic                              out_acc;

  always_comb begin
    adv[LastStage] = !vld_r[LastStage] || out_pix.ready;
    for (int k = LastStage - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < hsv2rgb_pkg::NumStages; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = (k == 0) ? in_pix.valid : vld_r[(k == 0) ? 0 : k - 1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctrl.load     = adv;
  assign in_pix.ready  = adv[0];
  assign out_pix.valid = vld_r[LastStage];
  assign in_acc        = in_pix.valid && in_pix.ready;
  assign out_acc       = out_pix.valid && out_pix.ready;

  hsv2rgb_datapath u_datapath (
    .clk        (clk),
    .ctrl       (ctrl),
    .hue        (in_pix.hue),
    .saturation (in_pix.saturation),
    .brightness (in_pix.brightness),
    .red        (out_pix.red),
    .green      (out_pix.green),
    .blue       (out_pix.blue)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> vld_r[0])
    else $error("accepted word did not enter first stage");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && adv[1] |=> vld_r[1])
    else $error("word lost between first and second stage");

  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      ($countones(vld_r) ==
       $countones($past(vld_r)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("pipeline occupancy does not match handshakes");

endmodule

/* test/hsv2rgb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB scoreboard
// Watches both pixel channels. Each accepted HSV word is turned into an
// expected RGB word by an exact integer hexcone model. Each RGB word that
// leaves the block is checked against the oldest expected word.
// ----------------------------------------------------------------------------
module hsv2rgb_checker
  import hsv2rgb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  hsv2rgb_in_if   in_mon,
  hsv2rgb_out_if  out_mon,
  output int      fail_count,
  output int      pending,
  output int      checked
);

  localparam longint unsigned FixScale = 64'd256 * 64'd256 * 64'd960;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  rgb_t expected_rgb[$];
  rgb_t want;

  function automatic logic [ChanW-1:0] scale_channel(longint unsigned part,
                                                     longint unsigned m);
    longint unsigned q;
    q = ((part + m) * 64'd255) / FixScale;
    if (q > 255) q = 255;
    return q[ChanW-1:0];
  endfunction

  function automatic rgb_t hexcone_rgb(logic [HueW-1:0] hue, logic [SatW-1:0] sat,
                                       logic [ValW-1:0] val);
    longint unsigned h, s, v, c, x, m, f, hdist, r1, g1, b1;
    rgb_t res;
    h = 64'(hue);
    s = 64'(sat);
    v = 64'(val);
    if (h >= HUE_FULL) h -= HUE_FULL;
    if (s > UNIT) s = UNIT;
    if (v > UNIT) v = UNIT;
    c = v * s * HUE_SECTOR;
    f = h % (2 * HUE_SECTOR);
    hdist = (f >= HUE_SECTOR) ? f - HUE_SECTOR : HUE_SECTOR - f;
    x = v * s * (HUE_SECTOR - hdist);
    m = v * UNIT * HUE_SECTOR - c;
    case (sector_t'(h / HUE_SECTOR))
      SECT_RY: begin r1 = c; g1 = x; b1 = 0; end
      SECT_YG: begin r1 = x; g1 = c; b1 = 0; end
      SECT_GC: begin r1 = 0; g1 = c; b1 = x; end
      SECT_CB: begin r1 = 0; g1 = x; b1 = c; end
      SECT_BM: begin r1 = x; g1 = 0; b1 = c; end
      default: begin r1 = c; g1 = 0; b1 = x; end
    endcase
    res.red   = scale_channel(r1, m);
    res.green = scale_channel(g1, m);
    res.blue  = scale_channel(b1, m);
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        expected_rgb.push_back(hexcone_rgb(in_mon.hue, in_mon.saturation,
                                           in_mon.brightness));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_rgb.size() == 0) begin
          $error("unexpected RGB word: red %0d green %0d blue %0d",
                 out_mon.red, out_mon.green, out_mon.blue);
          fail_count++;
        end else begin
          want = expected_rgb.pop_front();
          checked++;
          if (out_mon.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, out_mon.red);
            fail_count++;
          end
          if (out_mon.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, out_mon.green);
            fail_count++;
          end
          if (out_mon.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, out_mon.blue);
            fail_count++;
          end
        end
      end
      pending = expected_rgb.size();
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives HSV words with random gaps and random output stalls, including one
// long output hold that backs up the pipeline. A directed set covers hue,
// saturation and value extremes, every sector edge and the hue wrap; random
// words follow. The scoreboard module does all checking.
// ----------------------------------------------------------------------------
module tb;
  import hsv2rgb_pkg::*;

  localparam int NumRandom  = 830;
  localparam int StuckLimit = 1000;
  localparam int LongHold   = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  int fail_count, pending, checked;
  int sent_directed = 0;
  int sent_random = 0;
  int stuck = 0;
  int taken = 0;
  int rx_stall;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int pick;
  logic [HueW-1:0] rh;
  logic [SatW-1:0] rs;
  logic [ValW-1:0] rv;

  hsv2rgb_in_if  in_pix_if ();
  hsv2rgb_out_if out_pix_if ();

  hsv_to_rgb_converter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix_if),
    .out_pix (out_pix_if)
  );

  hsv2rgb_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_pix_if),
    .out_mon    (out_pix_if),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #5 clk = ~clk;

  initial begin
    in_pix_if.valid      = 1'b0;
    in_pix_if.hue        = '0;
    in_pix_if.saturation = '0;
    in_pix_if.brightness = '0;
    out_pix_if.ready     = 1'b0;
  end

  task automatic send_pixel(input logic [HueW-1:0] h, input logic [SatW-1:0] s,
                            input logic [ValW-1:0] v);
    int gap;
    @(negedge clk);
    if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_pix_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_pix_if.hue        = h;
    in_pix_if.saturation = s;
    in_pix_if.brightness = v;
    in_pix_if.valid      = 1'b1;
    do @(posedge clk); while (!in_pix_if.ready);
  endtask

  task automatic send_directed(input logic [HueW-1:0] h, input logic [SatW-1:0] s,
                               input logic [ValW-1:0] v);
    send_pixel(h, s, v);
    sent_directed++;
  endtask

  // output side: random stalls, burst stretches, one long hold
  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
      if (taken == 300) rx_stall = LongHold;
      else rx_stall = rx_burst ? 0 : $urandom_range(0, 16);
      if (rx_stall != 0) begin
        out_pix_if.ready = 1'b0;
        repeat (rx_stall) @(negedge clk);
      end
      out_pix_if.ready = 1'b1;
      do @(posedge clk); while (!out_pix_if.valid);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_pix_if.valid && in_pix_if.ready) ||
        (out_pix_if.valid && out_pix_if.ready))
      stuck = 0;
    else
      stuck++;
    if (stuck >= StuckLimit) begin
      $display("watchdog: no handshake for %0d cycles", StuckLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    send_directed(13'd0,    9'd256, 9'd256);
    send_directed(13'd959,  9'd256, 9'd256);
    send_directed(13'd960,  9'd256, 9'd256);
    send_directed(13'd1919, 9'd256, 9'd256);
    send_directed(13'd1920, 9'd200, 9'd256);
    send_directed(13'd2880, 9'd256, 9'd180);
    send_directed(13'd3840, 9'd128, 9'd256);
    send_directed(13'd4799, 9'd256, 9'd255);
    send_directed(13'd4800, 9'd255, 9'd256);
    send_directed(13'd5759, 9'd256, 9'd256);
    send_directed(13'd5760, 9'd256, 9'd256);
    send_directed(13'd8191, 9'd256, 9'd256);
    send_directed(13'd7000, 9'd100, 9'd200);
    send_directed(13'd480,  9'd0,   9'd256);
    send_directed(13'd480,  9'd0,   9'd0);
    send_directed(13'd480,  9'd256, 9'd0);
    send_directed(13'd1440, 9'd257, 9'd257);
    send_directed(13'd2400, 9'd511, 9'd511);
    send_directed(13'd3360, 9'd511, 9'd1);
    send_directed(13'd4320, 9'd1,   9'd511);
    send_directed(13'd5280, 9'd255, 9'd255);
    send_directed(13'd4096, 9'd384, 9'd170);
    send_directed(13'd2431, 9'd85,  9'd300);

    repeat (NumRandom) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        rh = HueW'($urandom_range(0, 5759));
        rs = SatW'($urandom_range(0, 256));
        rv = ValW'($urandom_range(0, 256));
      end else if (pick <= 7) begin
        rh = HueW'($urandom_range(0, 8191));
        rs = SatW'($urandom_range(0, 511));
        rv = ValW'($urandom_range(0, 511));
      end else begin
        // sector edges and unit extremes
        rh = HueW'($urandom_range(0, 7) * 960 + $urandom_range(0, 2) - 1);
        case ($urandom_range(0, 2))
          0: rs = 9'd0;
          1: rs = 9'd256;
          default: rs = 9'd511;
        endcase
        case ($urandom_range(0, 2))
          0: rv = 9'd0;
          1: rv = 9'd256;
          default: rv = ValW'($urandom_range(0, 511));
        endcase
      end
      send_pixel(rh, rs, rv);
      sent_random++;
    end

    @(negedge clk);
    in_pix_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);

    $display("sent %0d HSV words (%0d directed, %0d random), checked %0d RGB words",
             sent_directed + sent_random, sent_directed, sent_random, checked);
    $display("hue over all six sectors and the wrap range, s and v up to 511");
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
design/hsv2rgb_pkg.sv
design/hsv2rgb_if.sv
design/hsv2rgb_datapath.sv
design/hsv_to_rgb_converter.sv
test/hsv2rgb_checker.sv
test/tb.sv
